[design/bmt_pkg.sv]
// Shared types, codes and constants of the bitmap text renderer.
`timescale 1ns / 1ps

package bmt_pkg;

    // Default sizing of the glyph store and the glyph cell.
    localparam int GLYPH_COUNT_DEF = 96;
    localparam int MAX_COLUMNS_DEF = 5;
    localparam int MAX_ROWS_DEF    = 8;

    // Width of internal glyph store address arithmetic (covers 96 glyphs of 7 columns).
    localparam int CALC_W = 10;

    // Input operations.
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_CHAR  = 2'd2;
    localparam logic [1:0] OP_END   = 2'd3;

    // Result kinds.
    localparam logic KIND_BLOCK  = 1'b0;
    localparam logic KIND_LINE_Y = 1'b1;

    // Configuration register indexes.
    localparam logic [2:0] CFG_FONT_WIDTH  = 3'd0;
    localparam logic [2:0] CFG_FONT_HEIGHT = 3'd1;
    localparam logic [2:0] CFG_SCALE       = 3'd2;
    localparam logic [2:0] CFG_FG_COLOR    = 3'd3;
    localparam logic [2:0] CFG_BG_COLOR    = 3'd4;
    localparam logic [2:0] CFG_WRAP_ENABLE = 3'd5;
    localparam logic [2:0] CFG_MAX_WIDTH   = 3'd6;

    // Configuration reset values.
    localparam logic [2:0]  RST_FONT_WIDTH  = 3'd5;
    localparam logic [3:0]  RST_FONT_HEIGHT = 4'd7;
    localparam logic [3:0]  RST_SCALE       = 4'd1;
    localparam logic [15:0] RST_FG_COLOR    = 16'hFFFF;
    localparam logic [15:0] RST_BG_COLOR    = 16'h0000;
    localparam logic        RST_WRAP_ENABLE = 1'b0;
    localparam logic [15:0] RST_MAX_WIDTH   = 16'd128;

    // Character codes and colors with a special meaning.
    localparam logic [7:0]  CHAR_NEWLINE      = 8'h0A;
    localparam logic [7:0]  CHAR_FIRST        = 8'h20;
    localparam logic [7:0]  CHAR_LAST         = 8'h7F;
    localparam logic [7:0]  CHAR_QUESTION     = 8'h3F;
    localparam logic [15:0] COLOR_TRANSPARENT = 16'hFFFF;

    typedef struct packed {
        logic [1:0]         operation;
        logic [8:0]         glyph_index;
        logic [7:0]         glyph_bits;
        logic signed [15:0] start_x;
        logic signed [15:0] start_y;
        logic [7:0]         char_code;
    } in_word_t;

    typedef struct packed {
        logic               kind;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [15:0]        color;
        logic               last;
    } out_word_t;

    // Effective geometry and colors derived from the configuration registers.
    typedef struct packed {
        logic [2:0]  width;
        logic [3:0]  height;
        logic [3:0]  scale;
        logic [15:0] fg_color;
        logic [15:0] bg_color;
        logic        opaque;
        logic        wrap_en;
        logic [15:0] max_width;
        logic [6:0]  advance;
        logic [7:0]  line_h;
    } geo_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic store_wr;
        logic origin;
        logic newline;
        logic char_begin;
        logic report;
        logic fetch;
        logic pixel;
        logic gap;
        logic advance;
        logic flush;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] in_op;
        logic       in_newline;
        logic       skip_draw;
        logic       width_zero;
        logic       opaque;
        logic       go;
        logic       row_last;
        logic       col_last;
        logic       flush_done;
    } stat_t;

endpackage

[design/bmt_cfg.sv]
// Configuration registers and derived glyph geometry.
`timescale 1ns / 1ps

module bmt_cfg #(
    parameter int MAX_COLUMNS = bmt_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = bmt_pkg::MAX_ROWS_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cfg_valid,
    input  logic [2:0]     cfg_index,
    input  logic [15:0]    cfg_data,
    output bmt_pkg::geo_t  geo
);

    logic [2:0]  font_width_reg;
    logic [3:0]  font_height_reg;
    logic [3:0]  scale_reg;
    logic [15:0] fg_color_reg;
    logic [15:0] bg_color_reg;
    logic        wrap_enable_reg;
    logic [15:0] max_width_reg;

    logic [2:0]  w_eff;
    logic [3:0]  h_eff;
    logic [7:0]  adv_full;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            font_width_reg  <= bmt_pkg::RST_FONT_WIDTH;
            font_height_reg <= bmt_pkg::RST_FONT_HEIGHT;
            scale_reg       <= bmt_pkg::RST_SCALE;
            fg_color_reg    <= bmt_pkg::RST_FG_COLOR;
            bg_color_reg    <= bmt_pkg::RST_BG_COLOR;
            wrap_enable_reg <= bmt_pkg::RST_WRAP_ENABLE;
            max_width_reg   <= bmt_pkg::RST_MAX_WIDTH;
        end else if (cfg_valid) begin
            case (cfg_index)
                bmt_pkg::CFG_FONT_WIDTH:  font_width_reg  <= cfg_data[2:0];
                bmt_pkg::CFG_FONT_HEIGHT: font_height_reg <= cfg_data[3:0];
                bmt_pkg::CFG_SCALE:       scale_reg       <= cfg_data[3:0];
                bmt_pkg::CFG_FG_COLOR:    fg_color_reg    <= cfg_data;
                bmt_pkg::CFG_BG_COLOR:    bg_color_reg    <= cfg_data;
                bmt_pkg::CFG_WRAP_ENABLE: wrap_enable_reg <= cfg_data[0];
                bmt_pkg::CFG_MAX_WIDTH:   max_width_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Oversized fonts saturate to the glyph cell limits.
    always_comb begin
        w_eff = (font_width_reg > 3'(MAX_COLUMNS)) ? 3'(MAX_COLUMNS) : font_width_reg;
        h_eff = (font_height_reg > 4'(MAX_ROWS)) ? 4'(MAX_ROWS) : font_height_reg;
        adv_full = ({5'b0, w_eff} + 8'd1) * {4'b0, scale_reg};

        geo.width     = w_eff;
        geo.height    = h_eff;
        geo.scale     = scale_reg;
        geo.fg_color  = fg_color_reg;
        geo.bg_color  = bg_color_reg;
        geo.opaque    = (bg_color_reg != bmt_pkg::COLOR_TRANSPARENT);
        geo.wrap_en   = wrap_enable_reg;
        geo.max_width = max_width_reg;
        geo.advance   = adv_full[6:0];
        geo.line_h    = 8'(({4'b0, h_eff} + 8'd1) * {4'b0, scale_reg});
    end

endmodule

[design/bmt_ctrl.sv]
// Controller state machine that sequences glyph columns, rows and the gap column.
`timescale 1ns / 1ps

module bmt_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  bmt_pkg::stat_t  stat,
    output bmt_pkg::cmd_t   cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_FETCH,
        S_CELL,
        S_GAP,
        S_ADV,
        S_FLUSH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        s_ready    = (state_reg == S_IDLE);
        accept     = s_valid && s_ready;
        cmd        = '0;
        state_next = state_reg;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    case (stat.in_op)
                        bmt_pkg::OP_LOAD:  cmd.store_wr = 1'b1;
                        bmt_pkg::OP_START: cmd.origin = 1'b1;
                        bmt_pkg::OP_CHAR: begin
                            if (stat.in_newline) begin
                                cmd.newline = 1'b1;
                            end else begin
                                cmd.char_begin = 1'b1;
                                state_next     = S_SETUP;
                            end
                        end
                        bmt_pkg::OP_END: begin
                            cmd.report = 1'b1;
                            state_next = S_FLUSH;
                        end
                        default: ;
                    endcase
                end
            end
            S_SETUP: begin
                if (stat.skip_draw) begin
                    state_next = S_ADV;
                end else if (stat.width_zero) begin
                    state_next = stat.opaque ? S_GAP : S_ADV;
                end else begin
                    state_next = S_FETCH;
                end
            end
            S_FETCH: begin
                cmd.fetch  = 1'b1;
                state_next = S_CELL;
            end
            S_CELL: begin
                cmd.pixel = 1'b1;
                if (stat.go && stat.row_last) begin
                    if (stat.col_last) begin
                        state_next = stat.opaque ? S_GAP : S_ADV;
                    end else begin
                        state_next = S_FETCH;
                    end
                end
            end
            S_GAP: begin
                cmd.gap = 1'b1;
                if (stat.go && stat.row_last) begin
                    state_next = S_ADV;
                end
            end
            S_ADV: begin
                cmd.advance = 1'b1;
                state_next  = S_FLUSH;
            end
            S_FLUSH: begin
                cmd.flush = 1'b1;
                if (stat.flush_done) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

[design/bmt_dp.sv]
// Datapath: glyph store, cursor, block generation, pending word and output register.
`timescale 1ns / 1ps

module bmt_dp #(
    parameter int GLYPH_COUNT = bmt_pkg::GLYPH_COUNT_DEF,
    parameter int MAX_COLUMNS = bmt_pkg::MAX_COLUMNS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  bmt_pkg::in_word_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output bmt_pkg::out_word_t  m_data,
    input  bmt_pkg::geo_t       geo,
    input  bmt_pkg::cmd_t       cmd,
    output bmt_pkg::stat_t      stat
);

    localparam int STORE_DEPTH = GLYPH_COUNT * MAX_COLUMNS;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CALC_W_L    = bmt_pkg::CALC_W;

    logic [7:0] mem [STORE_DEPTH];

    logic [15:0] cursor_x_reg;
    logic [15:0] cursor_y_reg;
    logic [15:0] line_start_reg;
    logic [6:0]  glyph_reg;
    logic [2:0]  col_reg;
    logic [2:0]  row_reg;
    logic [6:0]  xoff_reg;
    logic [6:0]  yoff_reg;
    logic [7:0]  rd_data_reg;
    logic        rd_ok_reg;

    logic                pend_valid_reg;
    bmt_pkg::out_word_t  pend_data_reg;
    logic                out_valid_reg;
    bmt_pkg::out_word_t  out_data_reg;

    logic [7:0]          code_sel;
    logic [6:0]          glyph_num;
    logic signed [17:0]  span;
    logic signed [17:0]  limit;
    logic                wrap_take;
    logic [CALC_W_L-1:0] rd_addr;
    logic [CALC_W_L-1:0] wr_addr;
    logic                rd_in_range;
    logic                wr_in_range;
    logic [7:0]          col_bits;
    logic                cell_bit;
    logic                active;
    logic                wants;
    logic                out_free;
    logic                go;
    logic                push_new;
    logic                out_load;
    bmt_pkg::out_word_t  blk;
    bmt_pkg::out_word_t  line_rep;
    bmt_pkg::out_word_t  out_word;

    always_comb begin
        code_sel  = (s_data.char_code inside {[bmt_pkg::CHAR_FIRST:bmt_pkg::CHAR_LAST]})
                    ? s_data.char_code : bmt_pkg::CHAR_QUESTION;
        glyph_num = 7'(code_sel - bmt_pkg::CHAR_FIRST);

        // Wrap test at full precision: cursor + advance - line start against the limit.
        span = $signed({{2{cursor_x_reg[15]}}, cursor_x_reg})
             + $signed({11'b0, geo.advance})
             - $signed({{2{line_start_reg[15]}}, line_start_reg});
        limit     = $signed({{2{geo.max_width[15]}}, geo.max_width});
        wrap_take = geo.wrap_en && (span > limit);

        rd_addr     = CALC_W_L'(glyph_reg) * CALC_W_L'(geo.width) + CALC_W_L'(col_reg);
        rd_in_range = (rd_addr < CALC_W_L'(STORE_DEPTH));
        wr_addr     = CALC_W_L'(s_data.glyph_index);
        wr_in_range = (wr_addr < CALC_W_L'(STORE_DEPTH));

        col_bits = rd_ok_reg ? rd_data_reg : 8'h00;
        cell_bit = col_bits[row_reg];

        active   = cmd.pixel || cmd.gap;
        wants    = cmd.gap || geo.opaque || cell_bit;
        out_free = !out_valid_reg || m_ready;
        go       = !(wants && pend_valid_reg && !out_free);
        push_new = active && wants && go;
        out_load = (push_new && pend_valid_reg)
                || (cmd.flush && pend_valid_reg && out_free);

        blk.kind  = bmt_pkg::KIND_BLOCK;
        blk.pos_x = cursor_x_reg + {9'b0, xoff_reg};
        blk.pos_y = cursor_y_reg + {9'b0, yoff_reg};
        blk.color = (cmd.pixel && cell_bit) ? geo.fg_color : geo.bg_color;
        blk.last  = 1'b0;

        line_rep.kind  = bmt_pkg::KIND_LINE_Y;
        line_rep.pos_x = '0;
        line_rep.pos_y = cursor_y_reg + {8'b0, geo.line_h};
        line_rep.color = '0;
        line_rep.last  = 1'b0;

        // The word leaving the pending stage during a flush is the final one.
        out_word      = pend_data_reg;
        out_word.last = cmd.flush;

        stat.in_op      = s_data.operation;
        stat.in_newline = (s_data.char_code == bmt_pkg::CHAR_NEWLINE);
        stat.skip_draw  = (geo.scale == 4'd0) || (geo.height == 4'd0);
        stat.width_zero = (geo.width == 3'd0);
        stat.opaque     = geo.opaque;
        stat.go         = go;
        stat.row_last   = ({1'b0, row_reg} == (geo.height - 4'd1));
        stat.col_last   = (col_reg == (geo.width - 3'd1));
        stat.flush_done = !pend_valid_reg || out_free;
    end

    // Glyph store: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (cmd.store_wr && wr_in_range) begin
            mem[wr_addr[ADDR_W-1:0]] <= s_data.glyph_bits;
        end
        if (cmd.fetch) begin
            rd_data_reg <= mem[rd_addr[ADDR_W-1:0]];
            rd_ok_reg   <= rd_in_range;
        end
    end

    // Cursor state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_x_reg   <= '0;
            cursor_y_reg   <= '0;
            line_start_reg <= '0;
        end else begin
            if (cmd.origin) begin
                cursor_x_reg   <= s_data.start_x;
                line_start_reg <= s_data.start_x;
                cursor_y_reg   <= s_data.start_y;
            end else if (cmd.newline || (cmd.char_begin && wrap_take)) begin
                cursor_x_reg <= line_start_reg;
                cursor_y_reg <= cursor_y_reg + {8'b0, geo.line_h};
            end else if (cmd.advance) begin
                cursor_x_reg <= cursor_x_reg + {9'b0, geo.advance};
            end
        end
    end

    // Column and row walk through the glyph cell.
    always_ff @(posedge aclk) begin
        if (cmd.char_begin) begin
            glyph_reg <= glyph_num;
            col_reg   <= '0;
            row_reg   <= '0;
            xoff_reg  <= '0;
            yoff_reg  <= '0;
        end else if (active && go) begin
            if (stat.row_last) begin
                row_reg  <= '0;
                yoff_reg <= '0;
                if (cmd.pixel) begin
                    col_reg  <= col_reg + 3'd1;
                    xoff_reg <= xoff_reg + {3'b0, geo.scale};
                end
            end else begin
                row_reg  <= row_reg + 3'd1;
                yoff_reg <= yoff_reg + {3'b0, geo.scale};
            end
        end
    end

    // The pending word holds back one result so that the final one can carry last.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (push_new || cmd.report) begin
                pend_valid_reg <= 1'b1;
            end else if (out_load) begin
                pend_valid_reg <= 1'b0;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push_new) begin
            pend_data_reg <= blk;
        end else if (cmd.report) begin
            pend_data_reg <= line_rep;
        end
        if (out_load) begin
            out_data_reg <= out_word;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

[design/bitmap_text_renderer.sv]
// Top level of the bitmap text renderer: configuration, controller and datapath.
`timescale 1ns / 1ps

// The block turns a stream of input words into pixel block writes. A load word
// writes one column byte into the glyph store, a start word sets the string
// origin, a character word draws one glyph (or moves down a line for a newline)
// and an end word returns one word with the next line's y. Block writes come
// column by column, top row first, each one scale by scale pixels in size.
// Input, result and configuration channels each use valid and ready; the
// configuration port is always ready and must only be written while idle.
// Load, start and newline words give no result, and the block stays ready for
// the next word. For a drawn character, each glyph column begins with a
// registered glyph store read, followed by the rows of that column; an opaque
// background adds a trailing gap column. Results pass through a one-word
// holding stage, which lets the final result carry last, and then an output
// register; when the receiver stalls, the block waits with its current block
// and resumes without loss.
// Reset clears the cursor, line start and configuration; the glyph store keeps
// no reset and must be loaded before characters are drawn.

module bitmap_text_renderer #(
    parameter int GLYPH_COUNT = bmt_pkg::GLYPH_COUNT_DEF,
    parameter int MAX_COLUMNS = bmt_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = bmt_pkg::MAX_ROWS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  bmt_pkg::in_word_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output bmt_pkg::out_word_t  m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [15:0]         cfg_data
);

    bmt_pkg::geo_t  geo;
    bmt_pkg::cmd_t  cmd;
    bmt_pkg::stat_t stat;

    // The configuration port is always ready, so a register write is never held off.
    assign cfg_ready = 1'b1;

    bmt_cfg #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .geo       (geo)
    );

    // The controller walks the glyph columns, rows and gap column.
    bmt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // The datapath holds the glyph store, the cursor and the result stages.
    bmt_dp #(
        .GLYPH_COUNT (GLYPH_COUNT),
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .geo     (geo),
        .cmd     (cmd),
        .stat    (stat)
    );

endmodule

[sim/tb.sv]
// Self-checking testbench for the bitmap text renderer, with its own expected-result predictor.
`timescale 1ns / 1ps

// The testbench first loads the glyph entries that the stimulus will read: the
// first sixteen glyphs and the question mark at every font width, and the last
// printable glyph at the reset width. Printable codes in the random stimulus
// are folded onto those first sixteen glyphs, so no character ever reads a
// column byte that was never written. It then runs a few directed strings: the
// reset configuration, the extreme character codes, the extreme font geometries,
// transparent drawing, line wrapping and a long receiver hold-off. After that
// it sends random strings under random settings, with a little noise in between.
// Every accepted input word goes through a predictor that mirrors the glyph
// store, the cursor and the configuration. The predictor queues the block
// writes and line reports that the word must cause. A checker compares each
// result word with the oldest queued expectation, field by field.

module tb;
    import bmt_pkg::*;

    // The store holds one byte per column of every glyph.
    localparam int STORE_DEPTH = GLYPH_COUNT_DEF * MAX_COLUMNS_DEF;
    // Glyphs loaded for every width; printable codes are folded onto them.
    localparam int PRELOAD_GLYPHS = 16;
    localparam int PRELOAD_DEPTH  = PRELOAD_GLYPHS * MAX_COLUMNS_DEF;
    localparam int GLYPH_QUESTION = int'(CHAR_QUESTION) - int'(CHAR_FIRST);
    localparam int GLYPH_LAST     = int'(CHAR_LAST) - int'(CHAR_FIRST);
    // Cycles to let pass once nothing is expected. A character that draws
    // nothing can still keep the block busy while it walks the glyph cell.
    localparam int SETTLE_CYCLES = 120;
    // Length of the long receiver hold-off that fills the block up.
    localparam int HOLD_CYCLES = 800;
    // In the worst case every character gives 48 results, and each result waits
    // out the longest receiver stall; even so, this limit leaves a wide margin.
    localparam int LIMIT_CYCLES = 2_000_000;
    localparam int RANDOM_WORDS = 110;
    // Index 7 has no register behind it, and the block must ignore a write to it.
    localparam logic [2:0] CFG_SPARE = 3'd7;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    in_word_t    s_data    = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    out_word_t   m_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data  = '0;

    // These are the predictor's copies of the store, the configuration and the cursor.
    logic [7:0]  font_store [STORE_DEPTH];
    logic [2:0]  font_w;
    logic [3:0]  font_h;
    logic [3:0]  px_scale;
    logic [15:0] fg;
    logic [15:0] bg;
    logic        wrap_on;
    logic [15:0] wrap_limit;
    logic [15:0] cur_x;
    logic [15:0] cur_y;
    logic [15:0] line_x;

    // This queue holds the block writes and line reports still owed by the block, oldest first.
    out_word_t pending_draws [$];
    out_word_t due_word;

    // The sender and the receiver read these idling modes for every word.
    bit tx_idle      = 1'b1;
    bit rx_idle      = 1'b1;
    bit hold_request = 1'b0;

    int words_sent   = 0;
    int results_seen = 0;
    int cfg_writes   = 0;
    int glyphs_drawn = 0;
    int mismatches   = 0;

    always #4 aclk = ~aclk;

    bitmap_text_renderer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    function automatic logic [15:0] rand16();
        logic [31:0] r;
        r = $urandom;
        return r[15:0];
    endfunction

    // Printable codes fold onto the preloaded glyphs; any other code but a newline
    // draws the question mark, which is loaded for every width.
    function automatic logic [7:0] safe_code(logic [7:0] code);
        if (code >= CHAR_FIRST && code <= CHAR_LAST && code != CHAR_QUESTION) begin
            return CHAR_FIRST + {4'd0, code[3:0]};
        end
        return code;
    endfunction

    function automatic logic [7:0] random_code();
        return safe_code(8'($urandom_range(CHAR_FIRST, CHAR_LAST)));
    endfunction

    // A width above the cell limit saturates to that limit, and so does a height.
    function automatic int glyph_cols();
        return (font_w > MAX_COLUMNS_DEF) ? MAX_COLUMNS_DEF : int'(font_w);
    endfunction

    function automatic int glyph_rows();
        return (font_h > MAX_ROWS_DEF) ? MAX_ROWS_DEF : int'(font_h);
    endfunction

    function automatic out_word_t make_result(logic kind, int x, int y, logic [15:0] color);
        out_word_t r;
        r.kind  = kind;
        r.pos_x = x[15:0];
        r.pos_y = y[15:0];
        r.color = color;
        r.last  = 1'b0;
        return r;
    endfunction

    // Fields that the operation does not use get random values. The block
    // must ignore them.
    function automatic in_word_t make_word(logic [1:0] op);
        logic [63:0] noise;
        in_word_t    w;
        noise = {$urandom, $urandom};
        w = noise[$bits(in_word_t)-1:0];
        w.operation = op;
        return w;
    endfunction

    function automatic in_word_t load_word(logic [8:0] idx, logic [7:0] bits);
        in_word_t w;
        w = make_word(OP_LOAD);
        w.glyph_index = idx;
        w.glyph_bits  = bits;
        return w;
    endfunction

    function automatic in_word_t start_word(logic [15:0] x, logic [15:0] y);
        in_word_t w;
        w = make_word(OP_START);
        w.start_x = x;
        w.start_y = y;
        return w;
    endfunction

    function automatic in_word_t char_word(logic [7:0] code);
        in_word_t w;
        w = make_word(OP_CHAR);
        w.char_code = code;
        return w;
    endfunction

    // This task queues the blocks of one glyph at the cursor. The glyph is
    // drawn column by column, top row first. An opaque background adds a
    // trailing gap column.
    task automatic paint_glyph(logic [7:0] code);
        int         gw;
        int         gh;
        int         addr;
        int         col;
        int         row;
        logic [7:0] bits;
        logic       opaque;
        gw = glyph_cols();
        gh = glyph_rows();
        opaque = (bg != COLOR_TRANSPARENT);
        if (px_scale == 0) return;
        // Any code outside the printable range is drawn as a question mark.
        if (code < CHAR_FIRST || code > CHAR_LAST) code = CHAR_QUESTION;
        glyphs_drawn++;
        for (col = 0; col < gw; col++) begin
            addr = (int'(code) - int'(CHAR_FIRST)) * gw + col;
            bits = (addr < STORE_DEPTH) ? font_store[addr] : 8'h00;
            for (row = 0; row < gh; row++) begin
                if (opaque || bits[row]) begin
                    pending_draws.push_back(make_result(KIND_BLOCK, cur_x + col * px_scale,
                        cur_y + row * px_scale, bits[row] ? fg : bg));
                end
            end
        end
        if (opaque) begin
            for (row = 0; row < gh; row++) begin
                pending_draws.push_back(make_result(KIND_BLOCK, cur_x + gw * px_scale,
                    cur_y + row * px_scale, bg));
            end
        end
    endtask

    // This task steps the predictor by one accepted input word and queues
    // every result the word causes. The final queued result carries last.
    task automatic render_word(in_word_t w);
        int        adv;
        int        lh;
        int        span;
        int        n0;
        out_word_t tail;
        adv = (glyph_cols() + 1) * px_scale;
        lh  = (glyph_rows() + 1) * px_scale;
        n0  = pending_draws.size();
        case (w.operation)
            OP_LOAD: begin
                // A load beyond the end of the store is dropped.
                if (w.glyph_index < STORE_DEPTH) font_store[w.glyph_index] = w.glyph_bits;
            end
            OP_START: begin
                cur_x  = w.start_x;
                line_x = w.start_x;
                cur_y  = w.start_y;
            end
            OP_CHAR: begin
                if (w.char_code == CHAR_NEWLINE) begin
                    cur_y = 16'(cur_y + lh);
                    cur_x = line_x;
                end else begin
                    // The wrap test uses full precision, so the cursor's 16-bit
                    // wraparound does not fold the span back into range.
                    if (wrap_on) begin
                        span = int'($signed(cur_x)) + adv - int'($signed(line_x));
                        if (span > int'($signed(wrap_limit))) begin
                            cur_y = 16'(cur_y + lh);
                            cur_x = line_x;
                        end
                    end
                    paint_glyph(w.char_code);
                    cur_x = 16'(cur_x + adv);
                end
            end
            OP_END: begin
                pending_draws.push_back(make_result(KIND_LINE_Y, 0, cur_y + lh, 16'h0000));
            end
            default: ;
        endcase
        if (pending_draws.size() > n0) begin
            tail = pending_draws.pop_back();
            tail.last = 1'b1;
            pending_draws.push_back(tail);
        end
    endtask

    // This task offers one word after a random gap and holds it until the
    // block accepts it. When there is no gap, valid stays high from the
    // previous word.
    task automatic send_word(in_word_t w);
        int gap;
        gap = tx_idle ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        render_word(w);
        words_sent++;
    endtask

    // This task stops offering words and waits until every expected result
    // has come. It then lets the block finish any character that draws nothing.
    task automatic settle();
        s_valid <= 1'b0;
        while (pending_draws.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Callers keep cfg_valid high across a run of writes and drop it once at the end.
    task automatic write_reg(logic [2:0] idx, logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_writes++;
        case (idx)
            CFG_FONT_WIDTH:  font_w     = value[2:0];
            CFG_FONT_HEIGHT: font_h     = value[3:0];
            CFG_SCALE:       px_scale   = value[3:0];
            CFG_FG_COLOR:    fg         = value;
            CFG_BG_COLOR:    bg         = value;
            CFG_WRAP_ENABLE: wrap_on    = value[0];
            CFG_MAX_WIDTH:   wrap_limit = value;
            default: ;
        endcase
    endtask

    // This task waits for the block to go idle and then writes every
    // register. It ends with a write to the spare index, which must change nothing.
    task automatic load_settings(logic [2:0] w, logic [3:0] h, logic [3:0] s,
                                 logic [15:0] f, logic [15:0] b, logic wr,
                                 logic [15:0] mw);
        settle();
        write_reg(CFG_FONT_WIDTH, {13'd0, w});
        write_reg(CFG_FONT_HEIGHT, {12'd0, h});
        write_reg(CFG_SCALE, {12'd0, s});
        write_reg(CFG_FG_COLOR, f);
        write_reg(CFG_BG_COLOR, b);
        write_reg(CFG_WRAP_ENABLE, {15'd0, wr});
        write_reg(CFG_MAX_WIDTH, mw);
        write_reg(CFG_SPARE, rand16());
        cfg_valid <= 1'b0;
    endtask

    // The random settings favor the normal font range. The extremes still
    // come up now and then: zero and oversized geometry, zero scale, and a
    // transparent background or foreground.
    task automatic pick_random_settings();
        logic [2:0]  w;
        logic [3:0]  h;
        logic [3:0]  s;
        logic [15:0] f;
        logic [15:0] b;
        logic [15:0] mw;
        w = 3'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 5));
        h = 4'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8));
        s = 4'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 3));
        f = rand16();
        if ($urandom_range(0, 7) == 0) f = COLOR_TRANSPARENT;
        b = rand16();
        if ($urandom_range(0, 1) == 0) b = COLOR_TRANSPARENT;
        mw = ($urandom_range(0, 3) == 0) ? rand16() : 16'($urandom_range(0, 120));
        load_settings(w, h, s, f, b, 1'($urandom_range(0, 1)), mw);
    endtask

    // Every entry that a character can read is written before any character
    // is drawn. Two loads past the end of the store check that such words
    // are dropped.
    task automatic test_glyph_preload();
        int i;
        int w;
        for (i = 0; i < PRELOAD_DEPTH; i++) begin
            send_word(load_word(9'(i), 8'($urandom_range(0, 255))));
        end
        // The question mark stands in for every unprintable code, at any width.
        for (w = 1; w <= MAX_COLUMNS_DEF; w++) begin
            for (i = 0; i < w; i++) begin
                if (GLYPH_QUESTION * w + i >= PRELOAD_DEPTH) begin
                    send_word(load_word(9'(GLYPH_QUESTION * w + i), 8'($urandom_range(0, 255))));
                end
            end
        end
        // The last printable glyph is drawn only at the reset font width.
        for (i = 0; i < int'(RST_FONT_WIDTH); i++) begin
            send_word(load_word(9'(GLYPH_LAST * int'(RST_FONT_WIDTH) + i),
                                8'($urandom_range(0, 255))));
        end
        send_word(load_word(9'd480, 8'hFF));
        send_word(load_word(9'd511, 8'hA5));
    endtask

    // The configuration is still at its reset values: a 5x7 font at scale 1,
    // white on black, with the cursor at the origin.
    task automatic test_reset_defaults();
        send_word(char_word(8'h23));
        send_word(make_word(OP_END));
    endtask

    // These are the edges of the printable range and the codes just outside
    // it. The origin sits where x overflows and y is at its minimum.
    task automatic test_code_extremes();
        send_word(start_word(16'h7FFD, 16'h8000));
        send_word(char_word(8'h00));
        send_word(char_word(8'h1F));
        send_word(char_word(CHAR_FIRST));
        send_word(char_word(CHAR_LAST));
        send_word(char_word(8'h80));
        send_word(char_word(8'hFF));
        send_word(char_word(CHAR_NEWLINE));
        send_word(make_word(OP_END));
    endtask

    // This test covers oversized, zero-width and zero-height fonts, zero
    // scale, and transparent drawing with a foreground that is itself the
    // transparent code.
    task automatic test_geometry_extremes();
        load_settings(3'd7, 4'd15, 4'd15, rand16(), 16'h0000, 1'b0, 16'd128);
        send_word(char_word(8'h2D));
        load_settings(3'd0, 4'd8, 4'd2, rand16(), 16'h1234, 1'b0, 16'd128);
        send_word(char_word(8'h42));
        load_settings(3'd5, 4'd0, 4'd3, rand16(), 16'h00F0, 1'b0, 16'd128);
        send_word(char_word(8'h43));
        load_settings(3'd5, 4'd7, 4'd0, rand16(), 16'h0F00, 1'b0, 16'd128);
        send_word(char_word(8'h44));
        send_word(make_word(OP_END));
        load_settings(3'd5, 4'd7, 4'd1, COLOR_TRANSPARENT, COLOR_TRANSPARENT, 1'b0, 16'd128);
        send_word(char_word(8'h27));
    endtask

    // A narrow limit forces a wrap on the third character. The most negative
    // limit then wraps before every character.
    task automatic test_wrapping();
        load_settings(3'd5, 4'd7, 4'd1, rand16(), 16'h0000, 1'b1, 16'd14);
        send_word(start_word(16'd10, 16'd20));
        repeat (4) send_word(char_word(random_code()));
        send_word(make_word(OP_END));
        load_settings(3'd5, 4'd7, 4'd2, rand16(), COLOR_TRANSPARENT, 1'b1, 16'h8000);
        send_word(char_word(8'h2A));
    endtask

    // The receiver holds off for a long stretch while full-size glyphs keep
    // coming. The block's output fills up and it stops accepting input.
    task automatic test_output_backpressure();
        load_settings(3'd5, 4'd8, 4'd1, rand16(), 16'h0001, 1'b0, 16'd128);
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        hold_request = 1'b1;
        send_word(start_word(rand16(), rand16()));
        repeat (12) send_word(char_word(random_code()));
        send_word(make_word(OP_END));
        settle();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    // Most of the random stimulus is well-formed strings with random content.
    // The rest is short bursts of arbitrary words, among them stray loads that
    // rewrite store entries or fall beyond the store.
    task automatic test_random_strings();
        int         first;
        int         n;
        int         pick;
        logic [7:0] code;
        in_word_t   w;
        first = words_sent;
        while (words_sent - first < RANDOM_WORDS) begin
            if ($urandom_range(0, 2) == 0) pick_random_settings();
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 4) != 0) begin
                send_word(start_word(rand16(), rand16()));
                n = $urandom_range(1, 8);
                repeat (n) begin
                    pick = $urandom_range(0, 9);
                    if (pick == 0) code = CHAR_NEWLINE;
                    else if (pick == 1) code = safe_code(8'($urandom_range(0, 255)));
                    else code = random_code();
                    send_word(char_word(code));
                end
                send_word(make_word(OP_END));
            end else begin
                n = $urandom_range(1, 4);
                repeat (n) begin
                    w = make_word(2'($urandom_range(0, 3)));
                    if (w.operation == OP_CHAR) w.char_code = safe_code(w.char_code);
                    send_word(w);
                end
            end
        end
    endtask

    // The receiver draws a stall before each result word. A pending hold
    // request replaces that stall with the long hold-off.
    initial begin : receiver
        int stall;
        wait (aresetn === 1'b1);
        forever begin
            if (hold_request) begin
                stall = HOLD_CYCLES;
                hold_request = 1'b0;
            end else begin
                stall = rx_idle ? $urandom_range(0, 15) : 0;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
        end
    end

    // Each accepted result word is compared with the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_draws.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result word: kind %0d x %0d y %0d color %h last %0d",
                             m_data.kind, m_data.pos_x, m_data.pos_y, m_data.color,
                             m_data.last);
                end
            end else begin
                due_word = pending_draws.pop_front();
                if (m_data.kind !== due_word.kind || m_data.pos_x !== due_word.pos_x ||
                    m_data.pos_y !== due_word.pos_y || m_data.color !== due_word.color ||
                    m_data.last !== due_word.last) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("result %0d: expected kind %0d x %0d y %0d color %h last %0d",
                                 results_seen, due_word.kind, due_word.pos_x, due_word.pos_y,
                                 due_word.color, due_word.last);
                        $display("result %0d:      got kind %0d x %0d y %0d color %h last %0d",
                                 results_seen, m_data.kind, m_data.pos_x, m_data.pos_y,
                                 m_data.color, m_data.last);
                    end
                end
            end
        end
    end

    initial begin
        font_w     = RST_FONT_WIDTH;
        font_h     = RST_FONT_HEIGHT;
        px_scale   = RST_SCALE;
        fg         = RST_FG_COLOR;
        bg         = RST_BG_COLOR;
        wrap_on    = RST_WRAP_ENABLE;
        wrap_limit = RST_MAX_WIDTH;
        cur_x      = '0;
        cur_y      = '0;
        line_x     = '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_glyph_preload();
        test_reset_defaults();
        test_code_extremes();
        test_geometry_extremes();
        test_wrapping();
        test_output_backpressure();
        test_random_strings();
        settle();

        $display("Sent %0d input words and %0d register writes, and drew %0d glyphs.",
                 words_sent, cfg_writes, glyphs_drawn);
        $display("Checked %0d result words, with %0d mismatches.", results_seen, mismatches);
        if (mismatches == 0 && pending_draws.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        repeat (LIMIT_CYCLES) @(posedge aclk);
        $display("Timeout with %0d result words still expected.", pending_draws.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule

[filelist.f]
design/bmt_pkg.sv
design/bmt_cfg.sv
design/bmt_ctrl.sv
design/bmt_dp.sv
design/bitmap_text_renderer.sv
sim/tb.sv
